FILE: rtl/core/rcpa_pkg.sv
// Shared types and constants for the reference-counted page allocator.
// Used by rcpa_addr_map, rcpa_count_alu and refcounted_page_allocator; depends on nothing.
`timescale 1ns / 1ps

package rcpa_pkg;

    localparam int ADDR_W   = 56;
    localparam int DELTA_W  = 8;
    localparam int STATUS_W = 3;
    localparam int REF_W    = 16;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 56'h0000_0000_8000_0000;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_ADJUST = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_BADADDR = 3'd2,
        ST_UNDER   = 3'd3,
        ST_OVER    = 3'd4,
        ST_NONZERO = 3'd5
    } t_status;

    // Address check result for one request.
    typedef struct packed {
        logic in_range;
        logic aligned;
    } t_addr_chk;

    // Decision of the count update for one request.
    typedef struct packed {
        t_status status;
        logic    wr;
        logic    push;
        logic    pop;
        logic    alloc_ok;
    } t_alu_flags;

endpackage

FILE: rtl/core/rcpa_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Holds the free stack and the reference counts; no package dependency.
`timescale 1ns / 1ps

module rcpa_ram #(
    parameter  int DEPTH = 2,
    parameter  int WIDTH = 1,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds its value until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rcpa_addr_map.sv
// Pool base register and page address translation for the page allocator.
// Depends on rcpa_pkg.
`timescale 1ns / 1ps

module rcpa_addr_map #(
    parameter  int NUM_PAGES  = 1024,
    parameter  int PAGE_SHIFT = 12,
    localparam int IDX_W      = $clog2(NUM_PAGES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rcpa_pkg::ADDR_W-1:0] i_cfg_wdata,
    input  logic [rcpa_pkg::ADDR_W-1:0] i_page_address,
    input  logic [IDX_W-1:0]            i_alloc_idx,
    output logic [IDX_W-1:0]            o_idx,
    output rcpa_pkg::t_addr_chk         o_chk,
    output logic [rcpa_pkg::ADDR_W-1:0] o_alloc_address
);

    localparam int AW = rcpa_pkg::ADDR_W;
    localparam int PN_W = AW - PAGE_SHIFT;
    localparam logic [AW-1:0] PAGE_MASK = (AW'(1) << PAGE_SHIFT) - AW'(1);
    localparam logic [AW-1:0] BASE_RST  =
        (rcpa_pkg::HEAP_BASE_RST + PAGE_MASK) & ~PAGE_MASK;

    logic [AW-1:0]   r_pool_base;
    logic [AW-1:0]   cfg_round;
    logic [AW-1:0]   addr_down;
    logic [AW:0]     diff;
    logic [PN_W-1:0] page_num;

    // The base is rounded up to a page boundary once, when it is written.
    assign cfg_round = (i_cfg_wdata + PAGE_MASK) & ~PAGE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= BASE_RST;
        end else if (i_cfg_we) begin
            r_pool_base <= cfg_round;
        end
    end

    assign addr_down = i_page_address & ~PAGE_MASK;
    assign diff      = {1'b0, addr_down} - {1'b0, r_pool_base};
    assign page_num  = diff[AW-1:PAGE_SHIFT];

    // A borrow out of the subtraction means the address lies below the base.
    assign o_chk.in_range = !diff[AW] && (page_num < PN_W'(NUM_PAGES));
    assign o_chk.aligned  = ((i_page_address & PAGE_MASK) == '0);
    assign o_idx          = page_num[IDX_W-1:0];

    assign o_alloc_address = r_pool_base + (AW'(i_alloc_idx) << PAGE_SHIFT);

endmodule

FILE: rtl/core/rcpa_count_alu.sv
// Reference count update and status decision for one allocator request.
// Depends on rcpa_pkg.
`timescale 1ns / 1ps

module rcpa_count_alu #(
    parameter int COUNT_BITS = 16
) (
    input  rcpa_pkg::t_op                      i_op,
    input  logic                               i_bad,
    input  logic                               i_empty,
    input  logic                               i_full,
    input  logic [COUNT_BITS-1:0]              i_count,
    input  logic signed [rcpa_pkg::DELTA_W-1:0] i_delta,
    output logic [COUNT_BITS-1:0]              o_new_count,
    output logic [COUNT_BITS-1:0]              o_rpt_count,
    output rcpa_pkg::t_alu_flags               o_flags
);

    localparam int CW = COUNT_BITS;
    localparam int DW = rcpa_pkg::DELTA_W;
    localparam int SW = ((CW > DW) ? CW : DW) + 2;

    logic [SW-1:0] sum;
    logic          neg;
    logic          over;
    logic [CW-1:0] dec;

    assign sum  = {{(SW-CW){1'b0}}, i_count} + {{(SW-DW){i_delta[DW-1]}}, i_delta};
    assign neg  = sum[SW-1];
    assign over = !neg && (sum[SW-2:CW] != '0);
    assign dec  = i_count - CW'(1);

    always_comb begin
        o_flags.status   = rcpa_pkg::ST_OK;
        o_flags.wr       = 1'b0;
        o_flags.push     = 1'b0;
        o_flags.pop      = 1'b0;
        o_flags.alloc_ok = 1'b0;
        o_new_count      = i_count;
        o_rpt_count      = '0;
        case (i_op)
            rcpa_pkg::OP_ALLOC: begin
                if (i_empty) begin
                    o_flags.status = rcpa_pkg::ST_EMPTY;
                end else if (i_count != '0) begin
                    o_flags.status = rcpa_pkg::ST_NONZERO;
                    o_rpt_count    = i_count;
                end else begin
                    o_flags.pop      = 1'b1;
                    o_flags.wr       = 1'b1;
                    o_flags.alloc_ok = 1'b1;
                    o_new_count      = CW'(1);
                    o_rpt_count      = CW'(1);
                end
            end
            rcpa_pkg::OP_FREE: begin
                if (i_bad) begin
                    o_flags.status = rcpa_pkg::ST_BADADDR;
                end else if (i_count == '0) begin
                    o_flags.status = rcpa_pkg::ST_UNDER;
                end else begin
                    o_flags.wr   = 1'b1;
                    o_new_count  = dec;
                    o_rpt_count  = dec;
                    // On a full stack the count still drops but the push is skipped.
                    o_flags.push = (dec == '0) && !i_full;
                end
            end
            rcpa_pkg::OP_ADJUST: begin
                if (i_bad) begin
                    o_flags.status = rcpa_pkg::ST_BADADDR;
                end else if (neg) begin
                    o_flags.status = rcpa_pkg::ST_UNDER;
                    o_rpt_count    = i_count;
                end else if (over) begin
                    o_flags.status = rcpa_pkg::ST_OVER;
                    o_rpt_count    = i_count;
                end else begin
                    o_flags.wr  = 1'b1;
                    o_new_count = sum[CW-1:0];
                    o_rpt_count = sum[CW-1:0];
                end
            end
            rcpa_pkg::OP_READ: begin
                if (i_bad) begin
                    o_flags.status = rcpa_pkg::ST_BADADDR;
                end else begin
                    o_rpt_count = i_count;
                end
            end
            default: begin
                o_flags.status = rcpa_pkg::ST_OK;
            end
        endcase
    end

endmodule

FILE: rtl/core/refcounted_page_allocator.sv
// Reference-counted page allocator.
//
// Input channel: i_in_valid / o_in_stall carry one request (i_op, i_page_address,
// i_delta). Output channel: o_out_valid / i_out_stall carry one result per request
// (o_status, o_result_address, o_ref_count, o_returned_to_pool). A request or result
// moves at a rising edge where valid is high and stall is low.
// The heap base is written through i_cfg_we / i_cfg_wdata; the user must do so only
// while the block is idle, which the block does not enforce. The base is rounded up
// to a page boundary when written. Free, adjust and read first read the count
// memory, then update it. Alloc first reads the popped page index out of the free
// stack memory, since its count can only be read after that. The result is held in
// an output register, so the next request is accepted while a result waits; while
// the receiver stalls, a finished update waits in place. After reset a clearing pass
// writes page i into stack entry i and zeroes every count; o_in_stall stays high
// during the pass. Configuration writes are taken at any time.
// Depends on rcpa_pkg, rcpa_ram, rcpa_addr_map and rcpa_count_alu.
`timescale 1ns / 1ps

module refcounted_page_allocator #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rcpa_pkg::ADDR_W-1:0]        i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_op,
    input  logic [rcpa_pkg::ADDR_W-1:0]        i_page_address,
    input  logic signed [rcpa_pkg::DELTA_W-1:0] i_delta,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [rcpa_pkg::STATUS_W-1:0]      o_status,
    output logic [rcpa_pkg::ADDR_W-1:0]        o_result_address,
    output logic [rcpa_pkg::REF_W-1:0]         o_ref_count,
    output logic                               o_returned_to_pool
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int TOP_W = $clog2(NUM_PAGES + 1);
    localparam int CW    = COUNT_BITS;
    localparam int REF_W = rcpa_pkg::REF_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_STK,
        S_CNT
    } t_state;

    t_state                             r_state;
    logic [IDX_W-1:0]                   r_clr_idx;
    logic [TOP_W-1:0]                   r_top;
    rcpa_pkg::t_op                      r_op;
    logic [IDX_W-1:0]                   r_idx;
    logic                               r_bad;
    logic signed [rcpa_pkg::DELTA_W-1:0] r_delta;

    logic                               r_out_valid;
    logic [rcpa_pkg::STATUS_W-1:0]      r_status;
    logic [rcpa_pkg::ADDR_W-1:0]        r_result_address;
    logic [REF_W-1:0]                   r_ref_count;
    logic                               r_returned_to_pool;

    rcpa_pkg::t_op        in_op;
    logic                 accept;
    logic                 finish;
    logic                 clearing;
    logic [IDX_W-1:0]     map_idx;
    rcpa_pkg::t_addr_chk  map_chk;
    logic [rcpa_pkg::ADDR_W-1:0] alloc_address;
    logic                 in_bad;
    logic                 stk_we;
    logic [IDX_W-1:0]     stk_waddr;
    logic [IDX_W-1:0]     stk_wdata;
    logic                 stk_re;
    logic [TOP_W-1:0]     top_m1;
    logic [IDX_W-1:0]     stk_rdata;
    logic                 cnt_we;
    logic [IDX_W-1:0]     cnt_waddr;
    logic [CW-1:0]        cnt_wdata;
    logic                 cnt_re;
    logic [IDX_W-1:0]     cnt_raddr;
    logic [CW-1:0]        cnt_rdata;
    logic [CW-1:0]        new_count;
    logic [CW-1:0]        rpt_count;
    logic [CW+REF_W-1:0]  rpt_ext;
    rcpa_pkg::t_alu_flags alu;

    assign in_op    = rcpa_pkg::t_op'(i_op);
    assign clearing = (r_state == S_CLEAR);
    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign finish   = (r_state == S_CNT) && (!r_out_valid || !i_out_stall);
    assign in_bad   = !map_chk.in_range || ((in_op == rcpa_pkg::OP_FREE) && !map_chk.aligned);
    assign top_m1   = r_top - TOP_W'(1);

    rcpa_addr_map #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_addr_map (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_page_address  (i_page_address),
        .i_alloc_idx     (r_idx),
        .o_idx           (map_idx),
        .o_chk           (map_chk),
        .o_alloc_address (alloc_address)
    );

    // Free stack: the clearing pass writes entry i = i, a push writes at the top.
    assign stk_we    = clearing || (finish && alu.push);
    assign stk_waddr = clearing ? r_clr_idx : r_top[IDX_W-1:0];
    assign stk_wdata = clearing ? r_clr_idx : r_idx;
    assign stk_re    = accept && (in_op == rcpa_pkg::OP_ALLOC) && (r_top != '0);

    rcpa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (IDX_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (top_m1[IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    // Count memory: read at a good non-alloc accept, or after an alloc's stack read.
    assign cnt_we    = clearing || (finish && alu.wr);
    assign cnt_waddr = clearing ? r_clr_idx : r_idx;
    assign cnt_wdata = clearing ? '0 : new_count;
    assign cnt_re    = (accept && (in_op != rcpa_pkg::OP_ALLOC) && !in_bad) ||
                       (r_state == S_STK);
    assign cnt_raddr = (r_state == S_STK) ? stk_rdata : map_idx;

    rcpa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (CW)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    rcpa_count_alu #(
        .COUNT_BITS (CW)
    ) u_count_alu (
        .i_op        (r_op),
        .i_bad       (r_bad),
        .i_empty     (r_top == '0),
        .i_full      (r_top == TOP_W'(NUM_PAGES)),
        .i_count     (cnt_rdata),
        .i_delta     (r_delta),
        .o_new_count (new_count),
        .o_rpt_count (rpt_count),
        .o_flags     (alu)
    );

    assign rpt_ext = {{REF_W{1'b0}}, rpt_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_top       <= TOP_W'(NUM_PAGES);
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + IDX_W'(1);
                    if (r_clr_idx == IDX_W'(NUM_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= in_op;
                        r_idx   <= map_idx;
                        r_bad   <= in_bad;
                        r_delta <= i_delta;
                        r_state <= (in_op == rcpa_pkg::OP_ALLOC) ? S_STK : S_CNT;
                    end
                end
                S_STK: begin
                    r_idx   <= stk_rdata;
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    if (finish) begin
                        if (alu.pop) begin
                            r_top <= r_top - TOP_W'(1);
                        end else if (alu.push) begin
                            r_top <= r_top + TOP_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (finish) begin
            r_status           <= alu.status;
            r_result_address   <= alu.alloc_ok ? alloc_address : '0;
            r_ref_count        <= rpt_ext[REF_W-1:0];
            r_returned_to_pool <= alu.push;
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_result_address   = r_result_address;
    assign o_ref_count        = r_ref_count;
    assign o_returned_to_pool = r_returned_to_pool;

endmodule
